FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands shared by the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge; hold off while reset is asserted.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) prop) else $error(msg);

// Check a property on every rising edge, reset cycles included.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/mnep_pkg.sv
// ----------------------------------------------------------------------------
// mnep_pkg
// Types, codes and helpers shared by the MIDI note event parser.
// ----------------------------------------------------------------------------
package mnep_pkg;

    localparam int unsigned ByteW = 8;
    localparam int unsigned DataW = 7;
    localparam int unsigned ChanW = 4;

    // Running status: none, or high nibble 0x8..0xE mapped to 1..7.
    typedef enum logic [2:0] {
        ST_NONE      = 3'd0,
        ST_NOTE_OFF  = 3'd1,
        ST_NOTE_ON   = 3'd2,
        ST_POLY_PRES = 3'd3,
        ST_CONTROL   = 3'd4,
        ST_PROGRAM   = 3'd5,
        ST_PRESSURE  = 3'd6,
        ST_PITCH     = 3'd7
    } t_status;

    typedef struct packed {
        logic             valid;
        logic             pressed;
        logic [DataW-1:0] number;
        logic [DataW-1:0] velocity;
    } t_note;

    // Data bytes a message under the given status carries.
    function automatic logic [1:0] msg_len(input t_status st);
        logic [1:0] len;
        len = ((st == ST_PROGRAM) || (st == ST_PRESSURE)) ? 2'd1 : 2'd2;
        return len;
    endfunction

endpackage

FILE: rtl/mnep_parser.sv
// ----------------------------------------------------------------------------
// mnep_parser
// Running-status message tracker and note event decode for one byte a cycle while i_step is high.
// ----------------------------------------------------------------------------
module mnep_parser (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [mnep_pkg::ChanW-1:0] i_cfg_wdata,
    input  logic                       i_step,
    input  logic [mnep_pkg::ByteW-1:0] i_byte,
    output mnep_pkg::t_note            o_note
);
    import mnep_pkg::*;

    logic [ChanW-1:0] r_chan;
    t_status          r_status, n_status;
    logic [1:0]       r_due, n_due;
    logic [1:0]       r_taken, n_taken;
    logic [DataW-1:0] r_first, n_first;

    logic [1:0]       due_eff;
    logic [1:0]       taken_eff;
    logic [DataW-1:0] first_now;
    logic [DataW-1:0] data;

    assign data      = i_byte[DataW-1:0];
    assign due_eff   = (r_due == 2'd0) ? msg_len(r_status) : r_due;
    assign taken_eff = (r_due == 2'd0) ? 2'd0 : r_taken;
    assign first_now = (taken_eff == 2'd0) ? data : r_first;

    always_comb begin
        n_status = r_status;
        n_due    = r_due;
        n_taken  = r_taken;
        n_first  = r_first;
        o_note   = '0;
        if (i_step && (i_byte < 8'hF0)) begin
            if (i_byte[7]) begin
                // Status byte: start over, keep it only for our channel.
                n_taken = 2'd0;
                if (i_byte[3:0] == r_chan) begin
                    n_status = t_status'(i_byte[6:4] + 3'd1);
                    n_due    = msg_len(n_status);
                end else begin
                    n_status = ST_NONE;
                    n_due    = 2'd0;
                end
            end else if (r_status != ST_NONE) begin
                n_first = first_now;
                n_taken = taken_eff + 2'd1;
                n_due   = due_eff - 2'd1;
                if (n_due == 2'd0) begin
                    n_taken = 2'd0;
                    if (r_status == ST_NOTE_OFF) begin
                        o_note.valid    = 1'b1;
                        o_note.pressed  = 1'b0;
                        o_note.number   = first_now;
                        o_note.velocity = '0;
                    end else if (r_status == ST_NOTE_ON) begin
                        o_note.valid    = 1'b1;
                        o_note.pressed  = (data != '0);
                        o_note.number   = first_now;
                        o_note.velocity = data;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chan   <= '0;
            r_status <= ST_NONE;
            r_due    <= 2'd0;
            r_taken  <= 2'd0;
            r_first  <= '0;
        end else begin
            if (i_cfg_we) begin
                r_chan <= i_cfg_wdata;
            end
            r_status <= n_status;
            r_due    <= n_due;
            r_taken  <= n_taken;
            r_first  <= n_first;
        end
    end

endmodule

FILE: rtl/mnep_out_reg.sv
// ----------------------------------------------------------------------------
// mnep_out_reg
// Result register: hold one note event until the receiver takes it.
// ----------------------------------------------------------------------------
module mnep_out_reg (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  mnep_pkg::t_note            i_note,
    input  logic                       i_ready,
    output logic                       o_free,
    output logic                       o_valid,
    output logic                       o_pressed,
    output logic [mnep_pkg::DataW-1:0] o_number,
    output logic [mnep_pkg::DataW-1:0] o_velocity
);
    import mnep_pkg::*;

    logic             r_valid, n_valid;
    logic             r_pressed;
    logic [DataW-1:0] r_number;
    logic [DataW-1:0] r_velocity;

    assign o_free  = !r_valid || i_ready;
    assign n_valid = i_note.valid || (r_valid && !i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Payload loads whenever a fresh event arrives; this block does not check that the slot is free.
    always_ff @(posedge i_clk) begin
        if (i_note.valid) begin
            r_pressed  <= i_note.pressed;
            r_number   <= i_note.number;
            r_velocity <= i_note.velocity;
        end
    end

    assign o_valid    = r_valid;
    assign o_pressed  = r_pressed;
    assign o_number   = r_number;
    assign o_velocity = r_velocity;

endmodule

FILE: rtl/midi_note_event_parser_top.sv
// ----------------------------------------------------------------------------
// midi_note_event_parser_top
// MIDI byte stream to note event parser with running status.
// ----------------------------------------------------------------------------
// Usage:
//   Feed received MIDI bytes on the rx channel (i_rx_valid / o_rx_ready /
//   i_rx_byte). Note events leave on the note channel (o_note_valid /
//   i_note_ready / pressed, number, velocity). Only note-on and note-off for
//   the listened channel produce an item; a note-on of velocity zero is sent
//   as a release. Every other byte is absorbed silently.
//   Write the listened channel through i_cfg_we / i_cfg_wdata while idle.
// Flow:
//   One byte is taken every cycle unless stalled (see Stalls). A completing
//   byte is first held in the input register; once it can advance, the parser
//   decode loads the resulting event into the result register.
// Reset:
//   Synchronous, active low. Clears the running status, the data byte counts,
//   the listened channel (to 0) and both valid flags.
// Stalls:
//   While the receiver holds i_note_ready low with an event pending, the
//   input register holds its byte and o_rx_ready drops once it is full;
//   parser state only advances when the byte can move on, so nothing is lost.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module midi_note_event_parser_top (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [mnep_pkg::ChanW-1:0] i_cfg_wdata,
    input  logic                       i_rx_valid,
    output logic                       o_rx_ready,
    input  logic [mnep_pkg::ByteW-1:0] i_rx_byte,
    output logic                       o_note_valid,
    input  logic                       i_note_ready,
    output logic                       o_note_pressed,
    output logic [mnep_pkg::DataW-1:0] o_note_number,
    output logic [mnep_pkg::DataW-1:0] o_note_velocity
);
    import mnep_pkg::*;

    logic             r_in_valid, n_in_valid;
    logic [ByteW-1:0] r_in_byte;
    logic             out_free;
    logic             advance;
    t_note            note;

    // Advance the held byte whenever the result register can take an event.
    assign advance    = r_in_valid && out_free;
    assign o_rx_ready = !r_in_valid || out_free;
    assign n_in_valid = (i_rx_valid && o_rx_ready) || (r_in_valid && !advance);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
    end

    // Load the input register on acceptance; otherwise hold.
    always_ff @(posedge i_clk) begin
        if (i_rx_valid && o_rx_ready) begin
            r_in_byte <= i_rx_byte;
        end
    end

    mnep_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_step      (advance),
        .i_byte      (r_in_byte),
        .o_note      (note)
    );

    mnep_out_reg u_out_reg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_note     (note),
        .i_ready    (i_note_ready),
        .o_free     (out_free),
        .o_valid    (o_note_valid),
        .o_pressed  (o_note_pressed),
        .o_number   (o_note_number),
        .o_velocity (o_note_velocity)
    );

    // A byte left waiting in the input register must not change.
    `ASSERT_CLK(a_in_hold, i_clk, i_rst_n, r_in_valid && !advance |=> r_in_valid && $stable(r_in_byte), "input item lost or changed while stalled")
    // A release always carries zero velocity.
    `ASSERT_CLK(a_release_vel, i_clk, i_rst_n, o_note_valid && !o_note_pressed |-> o_note_velocity == '0, "release with nonzero velocity")
    // A press always carries a nonzero velocity.
    `ASSERT_CLK(a_press_vel, i_clk, i_rst_n, o_note_valid && o_note_pressed |-> o_note_velocity != '0, "press with zero velocity")
    // Reset empties both stages.
    `ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !o_note_valid && o_rx_ready, "pipeline not empty after reset")

endmodule
